FILE: hdl/sdjc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdjc_pkg
// Shared widths and constants of the stacked depth jet colormap.
// ----------------------------------------------------------------------------
package sdjc_pkg;
  localparam int DEPTH_W  = 32;
  localparam int PERIOD_W = 31;
  localparam int CHAN_W   = 8;
  localparam int RAMP_W   = 17;
  localparam int FRAC_W   = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd7680;

  localparam logic [RAMP_W-1:0] SEG1 = 17'd8192;
  localparam logic [RAMP_W-1:0] SEG3 = 17'd24576;
  localparam logic [RAMP_W-1:0] SEG5 = 17'd40960;
  localparam logic [RAMP_W-1:0] SEG7 = 17'd57344;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
  localparam logic [CHAN_W-1:0] RED_PEAK  = 8'd204;
endpackage

FILE: hdl/sdjc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdjc_depth_if / sdjc_rgb_if
// Valid/ready stream channels for depth items and RGB results.
// ----------------------------------------------------------------------------
interface sdjc_depth_if import sdjc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DEPTH_W-1:0] depth;
  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface sdjc_rgb_if import sdjc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hdl/stacked_depth_jet_colormap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stacked_depth_jet_colormap_core
// Depth to jet RGB with a programmable depth period, fully pipelined.
// ----------------------------------------------------------------------------
// One depth transfer is taken per cycle while the output is not stalled; its
// color passes 52 register stages (input register, 32 remainder stages, a
// fold stage, 17 quotient stages, an output register). The stage count is
// set by the two restoring dividers: the wrap of depth into the period
// resolves one dividend bit per stage, and the ramp quotient num*65536/P of
// the triangle numerator num one quotient bit per stage. The whole pipeline
// advances whenever the output register is empty or being drained, so a
// stalled result holds every stage in place. Write stack_period only while
// the pipeline is empty; a zero period gives the color of a zero ramp.
// ----------------------------------------------------------------------------
module stacked_depth_jet_colormap_core import sdjc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  sdjc_depth_if.sink          in_ch,
  sdjc_rgb_if.source          out_ch
);
  localparam int MOD_N = DEPTH_W;
  localparam int DIV_N = RAMP_W;

  logic [PERIOD_W-1:0] period_r;
  logic                adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  // Advance all stages together; hold when the result is stalled.
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Input stage: magnitude to wrap and the sign class of depth.
  logic               v0_r;
  logic [DEPTH_W-1:0] a0_r;
  logic               le0_r;
  logic               le_in;
  assign le_in = in_ch.depth[DEPTH_W-1] || (in_ch.depth == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      le0_r <= le_in;
      a0_r  <= le_in ? DEPTH_W'(-in_ch.depth) : DEPTH_W'(in_ch.depth - 1);
    end
  end

  // Remainder stages: a mod P, one dividend bit each.
  logic                mv_r  [MOD_N];
  logic [DEPTH_W-1:0]  ma_r  [MOD_N];
  logic [PERIOD_W-1:0] mrem_r[MOD_N];
  logic                mle_r [MOD_N];
  logic [DEPTH_W-1:0]  ma_src  [MOD_N];
  logic [PERIOD_W-1:0] mrem_src[MOD_N];
  logic                mle_src [MOD_N];
  logic                mv_src  [MOD_N];
  logic [PERIOD_W:0]   mshift  [MOD_N];
  logic [PERIOD_W-1:0] mrem_nxt[MOD_N];

  always_comb begin
    for (int i = 0; i < MOD_N; i++) begin
      if (i == 0) begin
        ma_src[i] = a0_r; mrem_src[i] = '0; mle_src[i] = le0_r; mv_src[i] = v0_r;
      end else begin
        ma_src[i] = ma_r[i-1]; mrem_src[i] = mrem_r[i-1];
        mle_src[i] = mle_r[i-1]; mv_src[i] = mv_r[i-1];
      end
      mshift[i] = {mrem_src[i], ma_src[i][DEPTH_W-1]};
      if (mshift[i] >= {1'b0, period_r}) begin
        mrem_nxt[i] = PERIOD_W'(mshift[i] - {1'b0, period_r});
      end else begin
        mrem_nxt[i] = mshift[i][PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOD_N; i++) mv_r[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < MOD_N; i++) mv_r[i] <= mv_src[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MOD_N; i++) begin
        ma_r[i]   <= {ma_src[i][DEPTH_W-2:0], 1'b0};
        mrem_r[i] <= mrem_nxt[i];
        mle_r[i]  <= mle_src[i];
      end
    end
  end

  // Fold stage: wrapped depth w, then the triangle numerator.
  logic                fv_r;
  logic [PERIOD_W-1:0] num_r;
  logic [PERIOD_W-1:0] rem_f;
  logic [PERIOD_W:0]   w_f;
  logic [PERIOD_W+1:0] w2_f;
  logic [PERIOD_W-1:0] num_nxt;

  always_comb begin
    rem_f = mrem_r[MOD_N-1];
    if (mle_r[MOD_N-1]) begin
      w_f = (rem_f == '0) ? '0 : ({1'b0, period_r} - {1'b0, rem_f});
    end else begin
      w_f = {1'b0, rem_f} + 1'b1;
    end
    w2_f = {w_f, 1'b0};
    if (w2_f <= {2'b00, period_r}) begin
      num_nxt = w2_f[PERIOD_W-1:0];
    end else begin
      num_nxt = PERIOD_W'({period_r, 1'b0} - w2_f);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (adv) begin
      fv_r <= mv_r[MOD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) num_r <= num_nxt;
  end

  // Quotient stages: num * 2^16 / P, one quotient bit each.
  logic                dv_r  [DIV_N];
  logic [PERIOD_W-1:0] drem_r[DIV_N];
  logic [RAMP_W-1:0]   dq_r  [DIV_N];
  logic [RAMP_W-1:0]   dq_src  [DIV_N];
  logic                dv_src  [DIV_N];
  logic [PERIOD_W:0]   dshift  [DIV_N];
  logic                dbit    [DIV_N];

  always_comb begin
    for (int i = 0; i < DIV_N; i++) begin
      if (i == 0) begin
        dq_src[i] = '0; dv_src[i] = fv_r;
        dshift[i] = {1'b0, num_r};
      end else begin
        dq_src[i] = dq_r[i-1]; dv_src[i] = dv_r[i-1];
        dshift[i] = {drem_r[i-1], 1'b0};
      end
      dbit[i] = (dshift[i] >= {1'b0, period_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_N; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < DIV_N; i++) dv_r[i] <= dv_src[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_N; i++) begin
        drem_r[i] <= dbit[i] ? PERIOD_W'(dshift[i] - {1'b0, period_r})
                             : dshift[i][PERIOD_W-1:0];
        dq_r[i]   <= {dq_src[i][RAMP_W-2:0], dbit[i]};
      end
    end
  end

  // Colormap stage: segment select and one narrow product per channel.
  logic [RAMP_W-1:0]   x_c;
  logic [FRAC_W-1:0]   t_c;
  logic [FRAC_W-1:0]   tinv_c;
  logic [FRAC_W+7:0]   prod_up;
  logic [FRAC_W+7:0]   prod_dn;
  logic [FRAC_W+7:0]   prod_r;
  logic [FRAC_W+7:0]   prod_b;
  logic [CHAN_W-1:0]   r_nxt, g_nxt, b_nxt;
  logic                ov_r;
  logic [CHAN_W-1:0]   red_r, green_r, blue_r;

  always_comb begin
    // Force a zero ramp when the period is zero.
    x_c = (period_r == '0) ? '0 : dq_r[DIV_N-1];
    if (x_c < SEG1)      t_c = FRAC_W'({x_c, 2'b00});
    else if (x_c < SEG3) t_c = FRAC_W'({x_c - SEG1, 2'b00});
    else if (x_c < SEG5) t_c = FRAC_W'({x_c - SEG3, 2'b00});
    else if (x_c < SEG7) t_c = FRAC_W'({x_c - SEG5, 2'b00});
    else                 t_c = FRAC_W'({x_c - SEG7, 2'b00});
    tinv_c  = FRAC_W'((1 << FRAC_W) - t_c);
    prod_up = CHAN_FULL * t_c;
    prod_dn = (t_c == '0) ? {CHAN_FULL, {FRAC_W{1'b0}}} : CHAN_FULL * tinv_c;
    prod_r  = RED_PEAK * t_c;
    prod_b  = CHAN_FULL * (FRAC_W'(1 << (FRAC_W - 1)) + t_c);
    priority if (x_c < SEG1) begin
      r_nxt = '0; g_nxt = '0; b_nxt = prod_b[FRAC_W+7:FRAC_W];
    end else if (x_c < SEG3) begin
      r_nxt = '0; g_nxt = prod_up[FRAC_W+7:FRAC_W]; b_nxt = CHAN_FULL;
    end else if (x_c < SEG5) begin
      r_nxt = prod_r[FRAC_W+7:FRAC_W]; g_nxt = CHAN_FULL;
      b_nxt = prod_dn[FRAC_W+7:FRAC_W];
    end else if (x_c < SEG7) begin
      r_nxt = RED_PEAK; g_nxt = prod_dn[FRAC_W+7:FRAC_W]; b_nxt = '0;
    end else begin
      r_nxt = CHAN_W'(({RED_PEAK, {FRAC_W{1'b0}}} - prod_up) >> FRAC_W);
      g_nxt = '0; b_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= r_nxt;
      green_r <= g_nxt;
      blue_r  <= b_nxt;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;
endmodule
